/* hdl/dtf_pkg.sv */
// Shared constants for the decimal text formatter.
// No dependencies; used by decimal_text_formatter_top.
`timescale 1ns / 1ps

package dtf_pkg;

   // Field widths of the stream words
   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 6;
   localparam int RSP_TDATA_W = 8;
   localparam int DIGIT_W     = 4;

   // Default maximum number of decimal digits printed
   localparam int DIGIT_COUNT_DEF = 5;

   // Double dabble split: input bits consumed per pipeline stage
   localparam int BITS_PER_STAGE = 8;
   localparam int DABBLE_STAGES  = VALUE_W / BITS_PER_STAGE;

   // ASCII code of the character '0'
   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

   // Largest legal BCD digit
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

endpackage

/* hdl/decimal_text_formatter_top.sv */
// Decimal text formatter: unsigned binary word in, ASCII decimal digits out.
// Depends on dtf_pkg for widths and constants.
`timescale 1ns / 1ps

// Each 32-bit input word is printed as its DIGIT_COUNT lowest decimal digits
// (value modulo 10^DIGIT_COUNT), most significant first, with leading zeros
// dropped; zero prints as a single '0'. tlast marks the least significant
// digit. A value yields 1 to DIGIT_COUNT characters, one character per cycle
// while rsp_tready is high, so the sustained rate is set by the character
// serializer at the output, which can load the next value as the last
// character of a run leaves. Conversion runs as a double dabble pipeline of
// DABBLE_STAGES stages (8 input bits each) followed by a leading-zero stage
// and the serializer, each of which holds its word while stalled. A new
// input word is accepted every cycle while the pipeline has room, also while
// a character waits on rsp_tready.
module decimal_text_formatter_top #(
   parameter int DIGIT_COUNT = dtf_pkg::DIGIT_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: [31:0] value
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dtf_pkg::VALUE_W-1:0]     req_tdata,
   // rsp_tdata: [5:0] digit_char, [7:6] zero; rsp_tlast: last_digit
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dtf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   localparam int BCD_W  = dtf_pkg::DIGIT_W * DIGIT_COUNT;
   localparam int POS_W  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int STAGES = dtf_pkg::DABBLE_STAGES;

   // Double dabble pipeline registers
   logic                        dab_valid_ff [STAGES];
   logic [dtf_pkg::VALUE_W-1:0] dab_bin_ff   [STAGES];
   logic [BCD_W-1:0]            dab_bcd_ff   [STAGES];
   logic [dtf_pkg::VALUE_W-1:0] dab_bin_in   [STAGES];
   logic [BCD_W-1:0]            dab_bcd_in   [STAGES];
   logic                        stage_rdy    [STAGES+1];

   // Leading-zero stage
   logic                        lead_valid_ff;
   logic [dtf_pkg::DIGIT_W-1:0] lead_digits_ff [DIGIT_COUNT];
   logic [POS_W-1:0]            lead_top_ff;
   logic [POS_W-1:0]            lead_top_in;

   // Serializer
   logic                        ser_valid_ff;
   logic [dtf_pkg::DIGIT_W-1:0] ser_digits_ff [DIGIT_COUNT];
   logic [POS_W-1:0]            ser_pos_ff;
   logic                        ser_free;
   logic                        ser_load;
   logic                        rsp_fire;
   logic [dtf_pkg::DIGIT_W-1:0] cur_digit;
   logic [dtf_pkg::CHAR_W-1:0]  cur_char;

   // Backpressure chain: a stage takes a word when empty or when it moves on
   assign stage_rdy[STAGES] = !lead_valid_ff || ser_free;
   assign req_tready        = stage_rdy[0];

   genvar s;
   generate
      for (s = 0; s < STAGES; s++) begin : g_dabble
         logic                        src_valid;
         logic [dtf_pkg::VALUE_W-1:0] src_bin;
         logic [BCD_W-1:0]            src_bcd;

         assign stage_rdy[s] = !dab_valid_ff[s] || stage_rdy[s+1];

         if (s == 0) begin : g_first
            assign src_valid = req_tvalid;
            assign src_bin   = req_tdata;
            assign src_bcd   = '0;
         end else begin : g_next
            assign src_valid = dab_valid_ff[s-1];
            assign src_bin   = dab_bin_ff[s-1];
            assign src_bcd   = dab_bcd_ff[s-1];
         end

         // Eight shift-and-correct steps; the carry out of the top digit
         // is dropped, which keeps the value modulo 10^DIGIT_COUNT
         always_comb begin
            logic [BCD_W-1:0]            b;
            logic [dtf_pkg::VALUE_W-1:0] v;
            b = src_bcd;
            v = src_bin;
            for (int step = 0; step < dtf_pkg::BITS_PER_STAGE; step++) begin
               for (int d = 0; d < DIGIT_COUNT; d++) begin
                  if (b[d*dtf_pkg::DIGIT_W +: dtf_pkg::DIGIT_W] >= 4'd5) begin
                     b[d*dtf_pkg::DIGIT_W +: dtf_pkg::DIGIT_W] =
                        b[d*dtf_pkg::DIGIT_W +: dtf_pkg::DIGIT_W] + 4'd3;
                  end
               end
               b = {b[BCD_W-2:0], v[dtf_pkg::VALUE_W-1]};
               v = {v[dtf_pkg::VALUE_W-2:0], 1'b0};
            end
            dab_bcd_in[s] = b;
            dab_bin_in[s] = v;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               dab_valid_ff[s] <= 1'b0;
            end else if (stage_rdy[s]) begin
               dab_valid_ff[s] <= src_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (stage_rdy[s] && src_valid) begin
               dab_bin_ff[s] <= dab_bin_in[s];
               dab_bcd_ff[s] <= dab_bcd_in[s];
            end
         end
      end
   endgenerate

   // Highest nonzero digit; digit 0 is always printed
   always_comb begin
      lead_top_in = '0;
      for (int d = 1; d < DIGIT_COUNT; d++) begin
         if (dab_bcd_ff[STAGES-1][d*dtf_pkg::DIGIT_W +: dtf_pkg::DIGIT_W] != '0) begin
            lead_top_in = POS_W'(d);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_valid_ff <= 1'b0;
      end else if (stage_rdy[STAGES]) begin
         lead_valid_ff <= dab_valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[STAGES] && dab_valid_ff[STAGES-1]) begin
         for (int d = 0; d < DIGIT_COUNT; d++) begin
            lead_digits_ff[d] <=
               dab_bcd_ff[STAGES-1][d*dtf_pkg::DIGIT_W +: dtf_pkg::DIGIT_W];
         end
         lead_top_ff <= lead_top_in;
      end
   end

   // Serializer: one character per output handshake, counting down to digit 0
   assign rsp_fire = ser_valid_ff && rsp_tready;
   assign ser_free = !ser_valid_ff || (rsp_tready && ser_pos_ff == '0);
   assign ser_load = lead_valid_ff && ser_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
      end else if (ser_load) begin
         ser_valid_ff <= 1'b1;
      end else if (rsp_fire && ser_pos_ff == '0) begin
         ser_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         ser_digits_ff <= lead_digits_ff;
         ser_pos_ff    <= lead_top_ff;
      end else if (rsp_fire && ser_pos_ff != '0) begin
         ser_pos_ff <= ser_pos_ff - 1'b1;
      end
   end

   // Output word
   assign cur_digit  = ser_digits_ff[ser_pos_ff];
   assign cur_char   = dtf_pkg::ASCII_ZERO + {2'b00, cur_digit};
   assign rsp_tvalid = ser_valid_ff;
   assign rsp_tdata  = {{(dtf_pkg::RSP_TDATA_W - dtf_pkg::CHAR_W){1'b0}}, cur_char};
   assign rsp_tlast  = (ser_pos_ff == '0);

   // Leading-zero stage points at a nonzero digit unless it points at digit 0
   a_lead_top_nonzero: assert property (@(posedge clock) disable iff (reset)
      lead_valid_ff && lead_top_ff != '0 |-> lead_digits_ff[lead_top_ff] != '0)
      else $error("leading digit is zero");

   // Serializer position stays inside the digit array
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff |-> ser_pos_ff <= POS_W'(DIGIT_COUNT - 1))
      else $error("serializer position out of range");

   // A new value only replaces a run whose last word is leaving
   a_load_after_last: assert property (@(posedge clock) disable iff (reset)
      ser_load && ser_valid_ff |-> rsp_tlast && rsp_tready)
      else $error("run overwritten before its last word");

   // Every emitted character is a decimal digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cur_digit <= dtf_pkg::DIGIT_MAX)
      else $error("non-decimal digit emitted");

   // A stalled leading-zero stage keeps its word
   a_lead_hold: assert property (@(posedge clock) disable iff (reset)
      lead_valid_ff && !ser_free |=> lead_valid_ff && $stable(lead_top_ff))
      else $error("leading-zero stage dropped a word");

endmodule
